FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file of the ready queue
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// implication checked on the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

FILE: src/pbrq_pkg.sv
// shared types, constants and a helper function for the priority ready queue
// no dependencies; imported by the top level, the ready map and the testbench
package pbrq_pkg;

   // fixed field widths and the row count
   localparam int LEVEL_W       = 6;
   localparam int HANDLE_PORT_W = 16;
   localparam int ROW_W         = 8;
   localparam int NUM_ROWS      = 8;
   localparam int IDX_W         = 3;

   // request operation codes
   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   // bitmap update command from the request decode
   typedef struct packed {
      logic               set;
      logic               clr;
      logic [LEVEL_W-1:0] level;
   } upd_type;

   // summary of the ready bitmap
   typedef struct packed {
      logic               any;
      logic [LEVEL_W-1:0] best;
   } status_type;

   // position of the lowest set bit of a byte, zero for zero
   function automatic logic [IDX_W-1:0] ffs8(input logic [ROW_W-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

endpackage

FILE: src/priority_bitmap_ready_queue.sv
// top level of the bitmap ready queue: request decode, pipeline and result register
// depends on pbrq_pkg, pbrq_slot_mem, pbrq_ready_map and assert_macros.svh
//
// Ready queue over MAX_LEVELS priority levels, one handle per level. A command
// is taken on any cycle with start high; busy stays low, so one command per
// cycle is sustained. Each command gives exactly one result, rsp_strobe high for
// one cycle, via the slot read register, then the result register. The result
// cannot be held off by the receiver, so it must be taken on that cycle.
// rsp_best_prio reflects state after the command, MAX_LEVELS-1 when nothing is
// ready. Reset clears the bitmap and flags only; it is usable the cycle after.
`include "assert_macros.svh"

module priority_bitmap_ready_queue
   import pbrq_pkg::*;
#(
   parameter int MAX_LEVELS   = 64,
   parameter int HANDLE_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_mode,
   input  logic [LEVEL_W-1:0]       req_prio,
   input  logic [HANDLE_PORT_W-1:0] req_task_handle,
   output logic                     rsp_strobe,
   output logic [HANDLE_PORT_W-1:0] rsp_removed_handle,
   output logic [LEVEL_W-1:0]       rsp_best_prio
);

   localparam int ADDR_W = $clog2(MAX_LEVELS);
   localparam int SLOT_W = (HANDLE_WIDTH < HANDLE_PORT_W) ? HANDLE_WIDTH : HANDLE_PORT_W;
   localparam logic [LEVEL_W-1:0] IDLE_LEVEL = LEVEL_W'(MAX_LEVELS - 1);

   logic                     accept;
   logic                     is_add;
   logic                     is_rem;
   logic [LEVEL_W:0]         prio_ext;
   logic                     in_range;
   logic                     below_idle;
   logic [LEVEL_W-1:0]       look_level;
   upd_type                  upd;
   status_type               map_status;
   logic                     look_hit_ff;
   logic [SLOT_W-1:0]        rd_data_ff;

   logic                     s1_valid_ff;
   logic                     s1_remove_ff;
   logic                     rsp_strobe_ff;
   logic [HANDLE_PORT_W-1:0] rsp_handle_ff;
   logic [HANDLE_PORT_W-1:0] rsp_handle_in;
   logic [LEVEL_W-1:0]       rsp_best_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // request decode
   always_comb begin
      is_add     = (req_mode == MODE_ADD);
      is_rem     = (req_mode == MODE_REMOVE);
      prio_ext   = {1'b0, req_prio};
      in_range   = prio_ext < (LEVEL_W + 1)'(MAX_LEVELS);
      below_idle = prio_ext < (LEVEL_W + 1)'(MAX_LEVELS - 1);
      upd.set    = accept && is_add && in_range;
      upd.clr    = accept && is_rem && below_idle;
      upd.level  = req_prio;
      look_level = (is_rem && !below_idle) ? IDLE_LEVEL : req_prio;
   end

   pbrq_slot_mem #(
      .DEPTH  (MAX_LEVELS),
      .DATA_W (SLOT_W),
      .ADDR_W (ADDR_W)
   ) u_slot_mem (
      .clock      (clock),
      .wr_en      (upd.set),
      .wr_addr    (req_prio[ADDR_W-1:0]),
      .wr_data    (req_task_handle[SLOT_W-1:0]),
      .rd_addr    (look_level[ADDR_W-1:0]),
      .rd_data_ff (rd_data_ff)
   );

   pbrq_ready_map #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_ready_map (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .look_level  (look_level),
      .look_hit_ff (look_hit_ff),
      .status      (map_status)
   );

   // handle reads as zero unless the command is a remove of a ready slot
   always_comb begin
      if (s1_remove_ff && look_hit_ff) rsp_handle_in = HANDLE_PORT_W'(rd_data_ff);
      else                             rsp_handle_in = '0;
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) s1_remove_ff <= is_rem;
      if (s1_valid_ff) begin
         rsp_handle_ff <= rsp_handle_in;
         rsp_best_ff   <= map_status.best;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_removed_handle = rsp_handle_ff;
   assign rsp_best_prio      = rsp_best_ff;

   // every command transfer is followed by a result strobe
   `ASSERT_IMPLY(a_rsp_follows_req, clock, reset, accept, ##2 rsp_strobe)
   // no result without a command
   `ASSERT_IMPLY(a_no_spurious_rsp, clock, reset, rsp_strobe, $past(accept, 2))
   // only removes hand back a handle
   `ASSERT_IMPLY(a_handle_only_on_remove, clock, reset,
      rsp_strobe && !$past(s1_remove_ff), rsp_removed_handle == '0)
   // empty bitmap reports the idle level
   `ASSERT_NEXT(a_idle_when_empty, clock, reset,
      s1_valid_ff && !map_status.any, rsp_best_prio == IDLE_LEVEL)

endmodule

FILE: src/pbrq_slot_mem.sv
// handle storage, one entry per priority level, registered read
// depends on nothing but its parameters
module pbrq_slot_mem #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 16,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

FILE: src/pbrq_ready_map.sv
// ready bitmap with row/group view and two-step lowest-level encoder
// depends on pbrq_pkg for the update and status types and ffs8
module pbrq_ready_map
   import pbrq_pkg::*;
#(
   parameter int MAX_LEVELS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  upd_type            upd,
   input  logic [LEVEL_W-1:0] look_level,
   output logic               look_hit_ff,
   output status_type         status
);

   localparam int LVL_W = $clog2(MAX_LEVELS);
   localparam int MAP_W = NUM_ROWS * ROW_W;

   logic [MAX_LEVELS-1:0] ready_ff;
   logic [MAX_LEVELS-1:0] ready_in;
   logic [MAP_W-1:0]      map;
   logic [NUM_ROWS-1:0]   group;
   logic [ROW_W-1:0]      row;
   logic [IDX_W-1:0]      row_idx;
   logic [IDX_W-1:0]      col_idx;

   // set or clear the addressed level
   always_comb begin
      ready_in = ready_ff;
      if (upd.set) ready_in[upd.level[LVL_W-1:0]] = 1'b1;
      if (upd.clr) ready_in[upd.level[LVL_W-1:0]] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff    <= '0;
         look_hit_ff <= 1'b0;
      end else begin
         ready_ff    <= ready_in;
         look_hit_ff <= ready_ff[look_level[LVL_W-1:0]];
      end
   end

   // group byte is the or of each row byte
   always_comb begin
      map = MAP_W'(ready_ff);
      for (int y = 0; y < NUM_ROWS; y++) begin
         group[y] = |map[y*ROW_W +: ROW_W];
      end
   end

   // first set bit of the group, then of the chosen row
   always_comb begin
      row_idx = ffs8(group);
      row     = map[row_idx*ROW_W +: ROW_W];
      col_idx = ffs8(row);
      status.any = |group;
      if (status.any) status.best = {row_idx, col_idx};
      else            status.best = LEVEL_W'(MAX_LEVELS - 1);
   end

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the priority bitmap ready queue
// depends on pbrq_pkg and the priority_bitmap_ready_queue rtl
`timescale 1ns / 100ps

module tb_top;
   import pbrq_pkg::*;

   localparam int NUM_LEVELS = 64;
   localparam logic [LEVEL_W-1:0] IDLE_LEVEL = LEVEL_W'(NUM_LEVELS - 1);
   // the unused fourth mode code, handled as a query
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int STALL_LIMIT = 200;
   localparam int DRAIN_CYCLES = 4;

   // one expected result
   typedef struct {
      logic [HANDLE_PORT_W-1:0] removed_handle;
      logic [LEVEL_W-1:0]       best_prio;
   } queue_result_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_mode = MODE_QUERY;
   logic [LEVEL_W-1:0]       req_prio = '0;
   logic [HANDLE_PORT_W-1:0] req_task_handle = '0;
   logic                     rsp_strobe;
   logic [HANDLE_PORT_W-1:0] rsp_removed_handle;
   logic [LEVEL_W-1:0]       rsp_best_prio;

   // predictor state: handle per level plus the two-level ready bitmap
   logic [HANDLE_PORT_W-1:0] level_handle [NUM_LEVELS];
   logic [ROW_W-1:0]         row_bits [NUM_ROWS];
   logic [ROW_W-1:0]         busy_rows;

   queue_result_type pending_results [$];

   // stimulus bookkeeping and run counters; sender_ready is kept by the sender only
   logic [NUM_LEVELS-1:0] sender_ready = '0;
   bit                    idling_on = 1'b0;
   int                    sent_count = 0;
   int                    result_count = 0;
   int                    error_count = 0;
   int                    add_count = 0;
   int                    remove_count = 0;
   int                    query_count = 0;
   int                    stall_cycles = 0;

   priority_bitmap_ready_queue dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_prio           (req_prio),
      .req_task_handle    (req_task_handle),
      .rsp_strobe         (rsp_strobe),
      .rsp_removed_handle (rsp_removed_handle),
      .rsp_best_prio      (rsp_best_prio)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // position of the lowest set bit, zero when nothing is set
   function automatic logic [IDX_W-1:0] lowest_set(input logic [ROW_W-1:0] bits);
      for (int i = 0; i < ROW_W; i++) begin
         if (bits[i]) return IDX_W'(i);
      end
      return '0;
   endfunction

   // most urgent ready level, idle level when the bitmap is empty
   function automatic logic [LEVEL_W-1:0] most_urgent_level();
      logic [IDX_W-1:0] row;
      if (busy_rows == '0) return IDLE_LEVEL;
      row = lowest_set(busy_rows);
      return {row, lowest_set(row_bits[row])};
   endfunction

   // apply one command to the predictor and return its result
   function automatic queue_result_type apply_command(input logic [1:0] mode,
                                                      input logic [LEVEL_W-1:0] prio,
                                                      input logic [HANDLE_PORT_W-1:0] handle);
      queue_result_type res;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      row = prio[LEVEL_W-1:IDX_W];
      col = prio[IDX_W-1:0];
      res.removed_handle = '0;
      if (mode == MODE_ADD) begin
         level_handle[prio] = handle;
         row_bits[row][col] = 1'b1;
         busy_rows[row] = 1'b1;
      end else if (mode == MODE_REMOVE) begin
         if (prio == IDLE_LEVEL) begin
            // the idle level is read but never cleared
            res.removed_handle = level_handle[IDLE_LEVEL];
         end else begin
            res.removed_handle = level_handle[prio];
            level_handle[prio] = '0;
            row_bits[row][col] = 1'b0;
            if (row_bits[row] == '0) busy_rows[row] = 1'b0;
         end
      end
      res.best_prio = most_urgent_level();
      return res;
   endfunction

   // compare one result transfer with the oldest expectation
   task automatic check_result();
      queue_result_type want;
      result_count++;
      if (pending_results.size() == 0) begin
         $error("result transfer with nothing expected: handle %h, best %0d",
                rsp_removed_handle, rsp_best_prio);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         if (rsp_removed_handle !== want.removed_handle) begin
            $error("removed_handle: expected %h, actual %h",
                   want.removed_handle, rsp_removed_handle);
            error_count++;
         end
         if (rsp_best_prio !== want.best_prio) begin
            $error("best_prio: expected %0d, actual %0d", want.best_prio, rsp_best_prio);
            error_count++;
         end
      end
   endtask

   // monitor: check results and predict every accepted command
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) check_result();
         if (start && !busy) begin
            pending_results.push_back(apply_command(req_mode, req_prio, req_task_handle));
            case (req_mode)
               MODE_ADD:    add_count++;
               MODE_REMOVE: remove_count++;
               default:     query_count++;
            endcase
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one command transfer; start stays high unless the caller idles
   task automatic send_cmd(input logic [1:0] mode, input logic [LEVEL_W-1:0] prio,
                           input logic [HANDLE_PORT_W-1:0] handle);
      start <= 1'b1;
      req_mode <= mode;
      req_prio <= prio;
      req_task_handle <= handle;
      do @(posedge clock); while (busy);
      sent_count++;
      if (mode == MODE_ADD) sender_ready[prio] = 1'b1;
      else if (mode == MODE_REMOVE && prio != IDLE_LEVEL) sender_ready[prio] = 1'b0;
   endtask

   // random idle burst between commands
   task automatic maybe_idle();
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // hold off until every expected result has come back
   task automatic wait_drained();
      start <= 1'b0;
      while (result_count < sent_count) @(posedge clock);
   endtask

   // level biased toward the first two rows so rows empty and refill often
   function automatic logic [LEVEL_W-1:0] pick_level();
      if ($urandom_range(0, 1) == 0) return LEVEL_W'($urandom_range(0, 15));
      return LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
   endfunction

   // a level that currently holds a task, random if none does
   function automatic logic [LEVEL_W-1:0] pick_ready_level();
      int base;
      base = $urandom_range(0, NUM_LEVELS - 1);
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (sender_ready[(base + i) % NUM_LEVELS]) return LEVEL_W'((base + i) % NUM_LEVELS);
      end
      return LEVEL_W'(base);
   endfunction

   // edge levels, every mode and the idle level cases
   task automatic test_directed();
      send_cmd(MODE_QUERY, 6'd0, 16'h0000);
      send_cmd(MODE_REMOVE, 6'd0, 16'hffff);
      send_cmd(MODE_REMOVE, IDLE_LEVEL, 16'hffff);
      send_cmd(MODE_ADD, 6'd0, 16'hffff);
      send_cmd(MODE_ADD, IDLE_LEVEL, 16'haaaa);
      send_cmd(MODE_ADD, 6'd7, 16'h5555);
      send_cmd(MODE_ADD, 6'd8, 16'h0001);
      send_cmd(MODE_ADD, 6'd56, 16'h8000);
      send_cmd(MODE_SPARE, 6'd5, 16'h1234);
      send_cmd(MODE_ADD, 6'd7, 16'h00ff);
      send_cmd(MODE_REMOVE, IDLE_LEVEL, 16'h0000);
      send_cmd(MODE_REMOVE, 6'd0, 16'h0000);
      send_cmd(MODE_REMOVE, 6'd7, 16'h0000);
      send_cmd(MODE_REMOVE, 6'd7, 16'h0000);
      send_cmd(MODE_REMOVE, 6'd8, 16'h0000);
      send_cmd(MODE_REMOVE, 6'd56, 16'h0000);
      send_cmd(MODE_QUERY, IDLE_LEVEL, 16'hffff);
      send_cmd(MODE_ADD, 6'd62, 16'hff00);
      send_cmd(MODE_REMOVE, 6'd62, 16'h0000);
      send_cmd(MODE_ADD, IDLE_LEVEL, 16'h0000);
      send_cmd(MODE_REMOVE, IDLE_LEVEL, 16'h0000);
      send_cmd(MODE_SPARE, IDLE_LEVEL, 16'hffff);
   endtask

   // random mix, mostly adds and removes of ready levels
   task automatic test_random_mix(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_cmd(MODE_ADD, pick_level(), HANDLE_PORT_W'($urandom));
         end else if (pick < 70) begin
            send_cmd(MODE_REMOVE, pick_ready_level(), HANDLE_PORT_W'($urandom));
         end else if (pick < 85) begin
            send_cmd(MODE_REMOVE, pick_level(), HANDLE_PORT_W'($urandom));
         end else if (pick < 90) begin
            send_cmd(MODE_REMOVE, IDLE_LEVEL, HANDLE_PORT_W'($urandom));
         end else if (pick < 95) begin
            send_cmd(MODE_QUERY, LEVEL_W'($urandom), HANDLE_PORT_W'($urandom));
         end else begin
            send_cmd(MODE_SPARE, LEVEL_W'($urandom), HANDLE_PORT_W'($urandom));
         end
         maybe_idle();
      end
   endtask

   // fill every level in random order, then empty them in random order
   task automatic test_fill_drain(input int rounds);
      logic [LEVEL_W-1:0] order [NUM_LEVELS];
      logic [LEVEL_W-1:0] tmp;
      int j;
      for (int r = 0; r < rounds; r++) begin
         for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < NUM_LEVELS; i++) order[i] = LEVEL_W'(i);
            for (int i = NUM_LEVELS - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (int i = 0; i < NUM_LEVELS; i++) begin
               send_cmd(pass == 0 ? MODE_ADD : MODE_REMOVE, order[i],
                        HANDLE_PORT_W'($urandom));
               maybe_idle();
            end
         end
      end
   endtask

   // sender stops until the queue of expectations is empty
   task automatic test_drain_pause();
      test_random_mix(30);
      wait_drained();
      test_random_mix(30);
   endtask

   initial begin
      for (int i = 0; i < NUM_LEVELS; i++) level_handle[i] = '0;
      for (int i = 0; i < NUM_ROWS; i++) row_bits[i] = '0;
      busy_rows = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      idling_on = 1'b1;
      test_random_mix(500);
      test_fill_drain(3);
      test_drain_pause();
      // closing stretch back to back
      idling_on = 1'b0;
      test_random_mix(350);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end

      $display("tb_top: %0d commands (%0d add, %0d remove, %0d query), %0d results checked",
               sent_count, add_count, remove_count, query_count, result_count);
      $display("tb_top: directed edges, random mix, full fill and empty, drain pause");
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
